[hw/rtl/lpe_pkg.sv]
// Package for the logarithmic posit encoder.
// Holds the value class codes and the fixed width of the logarithmic input.
// No dependencies.
`timescale 1ns / 1ps

package lpe_pkg;

  localparam int LOG_WIDTH = 32;

  typedef enum logic [1:0] {
    CLS_FINITE  = 2'd0,
    CLS_NAN     = 2'd1,
    CLS_POS_INF = 2'd2,
    CLS_NEG_INF = 2'd3
  } lpe_class_e;

endpackage

[hw/rtl/lpe_in_if.sv]
// Input channel of the logarithmic posit encoder: valid/ready plus payload.
// Depends on lpe_pkg.
`timescale 1ns / 1ps

interface lpe_in_if import lpe_pkg::*; ();

  logic                        valid;
  logic                        ready;
  logic                        sign;
  logic [1:0]                  value_class;
  logic signed [LOG_WIDTH-1:0] log_value;

  modport source (output valid, output sign, output value_class, output log_value,
                  input ready);
  modport sink (input valid, input sign, input value_class, input log_value,
                output ready);

endinterface

[hw/rtl/lpe_out_if.sv]
// Output channel of the logarithmic posit encoder: valid/ready plus posit word.
// No dependencies.
`timescale 1ns / 1ps

interface lpe_out_if #(
  parameter int POSIT_WIDTH = 16
) ();

  logic                   valid;
  logic                   ready;
  logic [POSIT_WIDTH-1:0] posit_word;

  modport source (output valid, output posit_word, input ready);
  modport sink (input valid, input posit_word, output ready);

endinterface

[hw/rtl/log_posit_encoder.sv]
// Logarithmic posit encoder: sign and fixed-point log value to posit word.
// Depends on lpe_pkg, lpe_in_if and lpe_out_if.
//
//   channel | direction | payload
//   --------+-----------+------------------------------------------
//   in_i    | sink      | sign, value_class, log_value
//   out_o   | source    | posit_word (POSIT_WIDTH bits)
//
// One transaction per cycle sustained while out_o is ready; an input register
// followed by the encode logic (negate, clamp, regime shift, round) and a
// result register.
// Reset empties both stages; payload registers are not reset.
// A stall on out_o holds the result register and backs up into the input stage.
`timescale 1ns / 1ps

module log_posit_encoder import lpe_pkg::*; #(
  parameter int POSIT_WIDTH = 16,
  parameter int FRAC_BITS   = 24
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  lpe_in_if.sink       in_i,
  lpe_out_if.source    out_o
);

  localparam int BOUND = 4 * (POSIT_WIDTH - 2);
  localparam int CLW   = $clog2(BOUND + 1) + 1;
  localparam int KW    = $clog2(POSIT_WIDTH);
  localparam int VW    = LOG_WIDTH + 1;
  localparam int CW    = VW + 1;
  localparam int EW    = FRAC_BITS + CW;
  localparam int TW    = FRAC_BITS + 3;
  localparam int FW    = POSIT_WIDTH - 1 + TW;

  localparam logic signed [CW-1:0]  BOUND_P  = CW'(BOUND);
  localparam logic signed [CW-1:0]  BOUND_M  = CW'(-BOUND);
  localparam logic signed [CLW-1:0] BOUND_PC = CLW'(BOUND);
  localparam logic signed [CLW-1:0] BOUND_MC = CLW'(-BOUND);
  localparam logic [KW-1:0]         K_MAX    = KW'(POSIT_WIDTH - 1);

  // input stage
  logic                        s1_valid_q;
  logic                        s1_sign_q;
  lpe_class_e                  s1_class_q;
  logic signed [LOG_WIDTH-1:0] s1_log_q;

  // result stage
  logic                   s2_valid_q;
  logic [POSIT_WIDTH-1:0] s2_word_q;
  logic [POSIT_WIDTH-1:0] s2_word_d;

  logic s1_ready;
  logic s2_ready;

  logic signed [VW-1:0]  v;
  logic signed [EW-1:0]  v_ext;
  logic signed [CW-1:0]  c_raw;
  logic [FRAC_BITS-1:0]  m_raw;
  logic signed [CLW-1:0] c_cl;
  logic [FRAC_BITS-1:0]  m_cl;
  logic signed [CLW-1:0] r;
  logic [CLW-1:0]        k_full;
  logic [KW-1:0]         k;
  logic [KW-1:0]         sh;
  logic                  r0b;
  logic [1:0]            e;
  logic [FW-1:0]         y;
  logic [FW-1:0]         f;
  logic [POSIT_WIDTH-2:0] kept;
  logic                  rbit;
  logic                  sticky;
  logic                  round_up;
  logic [POSIT_WIDTH-1:0] word_fin;

  assign s2_ready   = ~s2_valid_q | out_o.ready;
  assign s1_ready   = ~s1_valid_q | s2_ready;
  assign in_i.ready = s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_i.valid) begin
      s1_sign_q  <= in_i.sign;
      s1_class_q <= lpe_class_e'(in_i.value_class);
      s1_log_q   <= in_i.log_value;
    end
  end

  // split signed value into floor and fraction
  always_comb begin
    v     = s1_sign_q ? -{s1_log_q[LOG_WIDTH-1], s1_log_q} : {s1_log_q[LOG_WIDTH-1], s1_log_q};
    v_ext = {{(CW - VW + FRAC_BITS){v[VW-1]}}, v};
    c_raw = v_ext[EW-1:FRAC_BITS];
    m_raw = v_ext[FRAC_BITS-1:0];
  end

  // clamp to the representable range
  always_comb begin
    if (c_raw > BOUND_P || (c_raw == BOUND_P && m_raw != '0)) begin
      c_cl = BOUND_PC;
      m_cl = '0;
    end else if (c_raw < BOUND_M) begin
      c_cl = BOUND_MC;
      m_cl = '0;
    end else begin
      c_cl = c_raw[CLW-1:0];
      m_cl = m_raw;
    end
  end

  // regime, exponent and round to nearest even
  always_comb begin
    r0b      = c_cl[CLW-1];
    e        = c_cl[1:0];
    r        = c_cl >>> 2;
    k_full   = r[CLW-1] ? CLW'(-r) : CLW'(r + CLW'(1));
    k        = k_full[KW-1:0];
    sh       = K_MAX - k;
    y        = {{(POSIT_WIDTH-1){~r0b}}, r0b, e, m_cl};
    f        = y << sh;
    kept     = f[FW-1 -: POSIT_WIDTH-1];
    rbit     = f[FW-POSIT_WIDTH];
    sticky   = |f[FW-POSIT_WIDTH-1:0];
    round_up = rbit & (sticky | kept[0]);
    word_fin = {s1_sign_q, kept} + POSIT_WIDTH'(round_up);
  end

  always_comb begin
    case (s1_class_q)
      CLS_NAN,
      CLS_POS_INF: s2_word_d = {1'b1, {(POSIT_WIDTH-1){1'b0}}};
      CLS_NEG_INF: s2_word_d = '0;
      default:     s2_word_d = word_fin;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      s2_word_q <= s2_word_d;
    end
  end

  assign out_o.valid      = s2_valid_q;
  assign out_o.posit_word = s2_word_q;

endmodule

[bench/log_posit_encoder_tb.sv]
// Testbench for the logarithmic posit encoder: directed table, then random stream.
// Checks each posit word against a table entry or a predictor; depends on lpe_pkg, lpe_in_if, lpe_out_if.
`timescale 1ns / 1ps

module log_posit_encoder_tb;
  import lpe_pkg::*;

  localparam int PW         = 16;
  localparam int FB         = 24;
  localparam int QUIET_MAX  = 4000;
  localparam int N_ROWS     = 25;
  localparam int N_RAND_GAP = 430;
  localparam int N_RAND_END = 100;

  typedef logic [PW-1:0] posit_t;

  localparam posit_t NAR = {1'b1, {(PW-1){1'b0}}};

  typedef struct packed {
    logic       sign;
    lpe_class_e cls;
    logic [31:0] lv;
    logic       known;
    posit_t     word;
  } stim_row_t;

  typedef struct {
    logic        sign;
    lpe_class_e  cls;
    logic [31:0] lv;
    posit_t      word;
  } posit_exp_t;

  localparam stim_row_t DIRECTED_ROWS [N_ROWS] = '{
    '{1'b0, CLS_NAN,     32'h0000_0000, 1'b1, 16'h8000},
    '{1'b1, CLS_NAN,     32'h1234_5678, 1'b1, 16'h8000},
    '{1'b1, CLS_POS_INF, 32'hFFFF_FFFF, 1'b1, 16'h8000},
    '{1'b0, CLS_NEG_INF, 32'h0000_0000, 1'b1, 16'h0000},
    '{1'b1, CLS_NEG_INF, 32'h7FFF_FFFF, 1'b1, 16'h0000},
    '{1'b0, CLS_FINITE,  32'h0000_0000, 1'b1, 16'h4000},
    '{1'b1, CLS_FINITE,  32'h0000_0000, 1'b1, 16'hC000},
    '{1'b0, CLS_FINITE,  32'h7FFF_FFFF, 1'b1, 16'h7FFF},
    '{1'b1, CLS_FINITE,  32'h7FFF_FFFF, 1'b1, 16'h8001},
    '{1'b0, CLS_FINITE,  32'h8000_0000, 1'b1, 16'h0001},
    '{1'b1, CLS_FINITE,  32'h8000_0000, 1'b1, 16'hFFFF},
    '{1'b0, CLS_FINITE,  32'h3800_0000, 1'b0, 16'h0000},
    '{1'b0, CLS_FINITE,  32'h3800_0001, 1'b0, 16'h0000},
    '{1'b1, CLS_FINITE,  32'hC800_0000, 1'b0, 16'h0000},
    '{1'b0, CLS_FINITE,  32'h3700_0000, 1'b0, 16'h0000},
    '{1'b0, CLS_FINITE,  32'h3600_0000, 1'b0, 16'h0000},
    '{1'b0, CLS_FINITE,  32'h3680_0000, 1'b0, 16'h0000},
    '{1'b0, CLS_FINITE,  32'hCB00_0000, 1'b0, 16'h0000},
    '{1'b0, CLS_FINITE,  32'hCA00_0000, 1'b0, 16'h0000},
    '{1'b0, CLS_FINITE,  32'h3100_0000, 1'b0, 16'h0000},
    '{1'b0, CLS_FINITE,  32'h3140_0000, 1'b0, 16'h0000},
    '{1'b1, CLS_FINITE,  32'hCD00_0000, 1'b0, 16'h0000},
    '{1'b0, CLS_FINITE,  32'h2C80_0000, 1'b0, 16'h0000},
    '{1'b0, CLS_FINITE,  32'h0000_1000, 1'b0, 16'h0000},
    '{1'b1, CLS_FINITE,  32'hFFFF_D000, 1'b0, 16'h0000}
  };

  logic clk;
  logic rst_n;
  logic src_idle;
  logic snk_idle;
  int   mismatches;
  int   quiet_cycles;

  posit_exp_t expected_posits[$];

  lpe_in_if                        in_if ();
  lpe_out_if #(.POSIT_WIDTH(PW))   out_if ();

  log_posit_encoder #(
    .POSIT_WIDTH(PW),
    .FRAC_BITS  (FB)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if.sink),
    .out_o (out_if.source)
  );

  always #10 clk = ~clk;

  function automatic posit_t encode_log_posit(input logic sgn, input lpe_class_e cls,
                                              input logic [31:0] lv);
    longint      v;
    longint      c;
    longint      bound;
    logic [63:0] m;
    logic [63:0] body;
    logic [63:0] mant;
    logic [63:0] t;
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] half;
    logic [63:0] word;
    int          k;
    int          e;
    int          p;
    int          sh;
    logic        r0b;
    logic        lsb;
    mant = '0;
    if (cls == CLS_NAN || cls == CLS_POS_INF) return NAR;
    if (cls == CLS_NEG_INF) return '0;
    v = longint'(signed'(lv));
    if (sgn) v = -v;
    c = v >>> FB;
    m = 64'(v) & ((64'd1 << FB) - 1);
    bound = 4 * (PW - 2);
    if (c > bound || (c == bound && m != 0)) begin
      c = bound;
      m = '0;
    end else if (c < -bound) begin
      c = -bound;
      m = '0;
    end
    if (c >= 0) begin
      t = 64'(c + 4);
      e = int'(t[1:0]);
      k = int'(t >> 2);
      r0b = 1'b0;
    end else begin
      t = 64'(3 - c);
      e = 3 - int'(t[1:0]);
      k = int'(t >> 2);
      r0b = 1'b1;
    end
    body = r0b ? 64'd0 : (64'd1 << k) - 1;
    if (k >= PW - 1) begin
      if (r0b) body += (e == 0 && m == 0) ? {63'd0, body[0]} : 64'd1;
    end else if (k == PW - 2) begin
      body = {body[62:0], r0b};
      if (e == 3 || (e == 2 && m != 0)) body += 64'd1;
      else if (e == 2) body += {63'd0, body[0]};
    end else if (k == PW - 3) begin
      body = {body[61:0], r0b, e[1]};
      if (e[0]) body += (m != 0) ? 64'd1 : {63'd0, body[0]};
    end else begin
      p = PW - k - 4;
      body = {body[60:0], r0b, e[1:0]} << p;
      if (p >= FB) begin
        mant = m << (p - FB);
      end else begin
        sh   = FB - p;
        q    = m >> sh;
        rem  = m & ((64'd1 << sh) - 1);
        half = 64'd1 << (sh - 1);
        lsb  = (p > 0) ? q[0] : body[0];
        if (rem > half || (rem == half && lsb)) q += 64'd1;
        mant = q;
      end
    end
    word = (({63'd0, sgn} << (PW - 1)) | body) + mant;
    return word[PW-1:0];
  endfunction

  task automatic report_mismatch(input string what, input posit_t exp_word,
                                 input posit_t got_word);
    $display("mismatch at %0t: %s, expected %h got %h", $time, what, exp_word, got_word);
    mismatches++;
  endtask

  task automatic send_encode(input logic sgn, input lpe_class_e cls, input logic [31:0] lv,
                             input logic known, input posit_t word);
    posit_exp_t item;
    if (src_idle && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.sign        <= sgn;
    in_if.value_class <= cls;
    in_if.log_value   <= lv;
    do @(posedge clk); while (!in_if.ready);
    item.sign = sgn;
    item.cls  = cls;
    item.lv   = lv;
    item.word = known ? word : encode_log_posit(sgn, cls, lv);
    expected_posits.push_back(item);
  endtask

  task automatic pick_random(output logic sgn, output lpe_class_e cls,
                             output logic [31:0] lv);
    int          sel;
    int          ci;
    logic [31:0] frac;
    sel  = $urandom_range(0, 19);
    sgn  = 1'($urandom_range(0, 1));
    cls  = CLS_FINITE;
    ci   = $urandom_range(0, 114) - 57;
    frac = 32'($urandom_range(0, 3)) << $urandom_range(0, 22);
    if (sel == 0) begin
      cls = lpe_class_e'(2'($urandom_range(1, 3)));
      lv  = $urandom;
    end else if (sel < 5) begin
      lv = $urandom;
    end else if (sel < 12) begin
      lv = $urandom_range(0, 32'd2013265920) - 32'd1006632960;
    end else if (sel < 17) begin
      lv = (32'(ci) << FB) | (frac & 32'h00FF_FFFF);
    end else begin
      lv = (32'(ci) << FB) | ($urandom & 32'h00FF_FFFF);
    end
  endtask

  // result checking
  always @(posedge clk) begin
    posit_exp_t item;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_posits.size() == 0) begin
        report_mismatch("result with nothing pending", '0, out_if.posit_word);
      end else begin
        item = expected_posits.pop_front();
        if (out_if.posit_word !== item.word)
          report_mismatch($sformatf("sign %0b class %s log %h", item.sign, item.cls.name(),
                                    item.lv), item.word, out_if.posit_word);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_MAX) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    out_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (snk_idle && $urandom_range(0, 3) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  initial begin
    int          i;
    logic        sgn;
    lpe_class_e  cls;
    logic [31:0] lv;
    clk               = 1'b0;
    rst_n             = 1'b0;
    src_idle          = 1'b0;
    snk_idle          = 1'b0;
    mismatches        = 0;
    quiet_cycles      = 0;
    in_if.valid       = 1'b0;
    in_if.sign        = 1'b0;
    in_if.value_class = CLS_FINITE;
    in_if.log_value   = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < N_ROWS; i++)
      send_encode(DIRECTED_ROWS[i].sign, DIRECTED_ROWS[i].cls, DIRECTED_ROWS[i].lv,
                  DIRECTED_ROWS[i].known, DIRECTED_ROWS[i].word);

    src_idle = 1'b1;
    snk_idle = 1'b1;
    for (i = 0; i < N_RAND_GAP; i++) begin
      pick_random(sgn, cls, lv);
      send_encode(sgn, cls, lv, 1'b0, '0);
    end

    src_idle = 1'b0;
    snk_idle = 1'b0;
    for (i = 0; i < N_RAND_END; i++) begin
      pick_random(sgn, cls, lv);
      send_encode(sgn, cls, lv, 1'b0, '0);
    end
    in_if.valid <= 1'b0;

    while (expected_posits.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/lpe_pkg.sv
hw/rtl/lpe_in_if.sv
hw/rtl/lpe_out_if.sv
hw/rtl/log_posit_encoder.sv
bench/log_posit_encoder_tb.sv
